// ----- hw/rtl/bal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg: shared types and codes for the bounded array list
// Request function codes, result status codes and the command word that
// the controller broadcasts to every storage cell of the chain.
// ----------------------------------------------------------------------------
package bal_pkg;

	// Request function codes
	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOCATE = 2'd2,
		FUNC_SORTED = 2'd3
	} func_t;

	// Result status codes
	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_REJECT    = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	// Data move that every cell performs in the current cycle
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_SORTED = 2'd3
	} cell_cmd_t;

	// Broadcast from the controller to the cells
	typedef struct packed {
		cell_cmd_t          cmd;
		logic signed [31:0] value;
		logic [3:0]         position;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/bal_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_if: request and response channels of the bounded array list
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bal_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] value;
	logic [3:0]         position;

	modport source (output valid, output func, output value, output position, input ready);
	modport sink (input valid, input func, input value, input position, output ready);
endinterface

interface bal_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] found_index;
	logic [4:0] fill_count;

	modport source (output valid, output status, output found_index, output fill_count,
		input ready);
	modport sink (input valid, input status, input found_index, input fill_count,
		output ready);
endinterface

// ----- hw/rtl/bal_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_cell: one storage cell of the list chain
// Holds one entry, shifts it to or from its neighbors on insert and delete,
// and forwards two search flags along the chain one cell per cycle: the
// first-match flag and index upward, the less-or-equal flag downward.
// ----------------------------------------------------------------------------
module bal_cell #(
	parameter int CELL_INDEX = 0,
	parameter int CW         = 5,
	parameter int IW         = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bal_pkg::cell_ctrl_t  ctrl,
	input  logic [CW-1:0]        count,
	input  logic signed [31:0]   left_data,
	input  logic signed [31:0]   right_data,
	output logic signed [31:0]   data,
	input  logic                 le_above,
	input  logic                 le_below,
	output logic                 le_here,
	input  logic                 found_in,
	input  logic [IW-1:0]        idx_in,
	output logic                 found_out,
	output logic [IW-1:0]        idx_out
);

	localparam int CMPW = (CW > 4) ? CW : 4;

	logic signed [31:0] data_q;
	logic signed [31:0] data_d;
	logic               le_q;
	logic               found_q;
	logic [IW-1:0]      idx_q;
	logic [CMPW-1:0]    my_idx;
	logic [CMPW-1:0]    pos_c;
	logic [CMPW-1:0]    cnt_c;
	logic               occupied;
	logic               hit_eq;
	logic               hit_le;

	// Compare own place against the request and the fill count
	assign my_idx   = CMPW'(CELL_INDEX);
	assign pos_c    = CMPW'(ctrl.position);
	assign cnt_c    = CMPW'(count);
	assign occupied = my_idx < cnt_c;
	assign hit_eq   = occupied && (data_q == ctrl.value);
	assign hit_le   = occupied && (data_q <= ctrl.value);

	// Select the next entry value
	always_comb begin
		data_d = data_q;
		case (ctrl.cmd)
			bal_pkg::CMD_INSERT: begin
				if (my_idx > pos_c) begin
					data_d = left_data;
				end else if (my_idx == pos_c) begin
					data_d = ctrl.value;
				end
			end
			bal_pkg::CMD_DELETE: begin
				if (my_idx >= pos_c) begin
					data_d = right_data;
				end
			end
			bal_pkg::CMD_SORTED: begin
				// no smaller-or-equal entry at or above: the value lands here or moves up
				if (!le_q) begin
					data_d = le_below ? ctrl.value : left_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// Advance the search flags by one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q    <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			le_q    <= hit_le | le_above;
			found_q <= hit_eq | found_in;
			idx_q   <= found_in ? idx_in : IW'(CELL_INDEX);
		end
	end

	assign data      = data_q;
	assign le_here   = le_q;
	assign found_out = found_q;
	assign idx_out   = idx_q;

endmodule

// ----- hw/rtl/bounded_array_list_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_top: bounded list with insert, delete, locate, sorted insert
// A rejected request goes straight to the hand-off; positional insert and delete
// pass through the apply step first; locate and sorted insert scan, then apply.
// The next item is taken once the result is in the output register, once free.
// Locate and sorted insert wait for the search flags to ripple through all
// CAPACITY cells, one cell per cycle; that wave sets their latency.
// One item at a time; a new one is taken while the last result waits.
// Reset empties the list (fill count zero) and drops any pending result.
// ----------------------------------------------------------------------------
module bounded_array_list_top #(
	parameter int CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	bal_req_if.sink  req,
	bal_rsp_if.source rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > 4) ? CW : 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_WAIT
	} state_t;

	state_t               state_q;
	bal_pkg::cell_ctrl_t  ctrl_q;
	bal_pkg::func_t       func_q;
	bal_pkg::func_t       req_func;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        scan_cnt_q;
	logic [1:0]           res_status_q;
	logic [3:0]           res_index_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [3:0]           out_index_q;
	logic [4:0]           out_fill_q;

	logic signed [31:0]   data_w  [CAPACITY];
	logic                 le_w    [CAPACITY];
	logic                 found_w [CAPACITY];
	logic [IW-1:0]        idx_w   [CAPACITY];

	logic                 full;
	logic [CMPW-1:0]      pos_ext;
	logic [CMPW-1:0]      cnt_ext;
	logic [IW+3:0]        idx_wide;
	logic [3:0]           idx_lo;
	logic [CW+4:0]        cnt_wide;
	logic [4:0]           cnt_lo;

	// Request checks against the fill count
	assign req_func = bal_pkg::func_t'(req.func);
	assign full     = count_q == CW'(CAPACITY);
	assign pos_ext  = CMPW'(req.position);
	assign cnt_ext  = CMPW'(count_q);

	// Trim the search result and count to the result field widths
	assign idx_wide = {4'b0000, idx_w[CAPACITY-1]};
	assign idx_lo   = idx_wide[3:0];
	assign cnt_wide = {5'b00000, count_q};
	assign cnt_lo   = cnt_wide[4:0];

	// Chain of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_c;
		logic signed [31:0] right_c;
		logic               above_c;
		logic               below_c;
		logic               found_c;
		logic [IW-1:0]      idx_c;

		if (g == 0) begin : g_first
			assign left_c  = 32'sd0;
			assign below_c = 1'b1;
			assign found_c = 1'b0;
			assign idx_c   = '0;
		end else begin : g_inner_lo
			assign left_c  = data_w[g-1];
			assign below_c = le_w[g-1];
			assign found_c = found_w[g-1];
			assign idx_c   = idx_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_c = data_w[g];
			assign above_c = 1'b0;
		end else begin : g_inner_hi
			assign right_c = data_w[g+1];
			assign above_c = le_w[g+1];
		end

		bal_cell #(
			.CELL_INDEX (g),
			.CW         (CW),
			.IW         (IW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl_q),
			.count      (count_q),
			.left_data  (left_c),
			.right_data (right_c),
			.data       (data_w[g]),
			.le_above   (above_c),
			.le_below   (below_c),
			.le_here    (le_w[g]),
			.found_in   (found_c),
			.idx_in     (idx_c),
			.found_out  (found_w[g]),
			.idx_out    (idx_w[g])
		);
	end

	// Sequence one item: check, scan, apply, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ctrl_q.cmd     <= bal_pkg::CMD_HOLD;
			ctrl_q.value   <= 32'sd0;
			ctrl_q.position <= 4'd0;
			func_q         <= bal_pkg::FUNC_INSERT;
			count_q        <= '0;
			scan_cnt_q     <= '0;
			res_status_q   <= bal_pkg::STATUS_DONE;
			res_index_q    <= 4'd0;
			out_valid_q    <= 1'b0;
			out_status_q   <= bal_pkg::STATUS_DONE;
			out_index_q    <= 4'd0;
			out_fill_q     <= 5'd0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						ctrl_q.value    <= req.value;
						ctrl_q.position <= req.position;
						func_q          <= req_func;
						res_status_q    <= bal_pkg::STATUS_DONE;
						res_index_q     <= 4'd0;
						scan_cnt_q      <= '0;
						case (req_func)
							bal_pkg::FUNC_INSERT: begin
								if (full || (pos_ext > cnt_ext)) begin
									res_status_q <= bal_pkg::STATUS_REJECT;
									state_q      <= ST_WAIT;
								end else begin
									ctrl_q.cmd <= bal_pkg::CMD_INSERT;
									state_q    <= ST_APPLY;
								end
							end
							bal_pkg::FUNC_DELETE: begin
								if (pos_ext >= cnt_ext) begin
									res_status_q <= bal_pkg::STATUS_REJECT;
									state_q      <= ST_WAIT;
								end else begin
									ctrl_q.cmd <= bal_pkg::CMD_DELETE;
									state_q    <= ST_APPLY;
								end
							end
							bal_pkg::FUNC_LOCATE: begin
								state_q <= ST_SCAN;
							end
							default: begin
								if (full) begin
									res_status_q <= bal_pkg::STATUS_REJECT;
									state_q      <= ST_WAIT;
								end else begin
									state_q <= ST_SCAN;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					// let the flags cross every cell
					scan_cnt_q <= scan_cnt_q + IW'(1);
					if (scan_cnt_q == IW'(CAPACITY - 1)) begin
						state_q <= ST_APPLY;
						if (func_q == bal_pkg::FUNC_SORTED) begin
							ctrl_q.cmd <= bal_pkg::CMD_SORTED;
						end
					end
				end
				ST_APPLY: begin
					ctrl_q.cmd <= bal_pkg::CMD_HOLD;
					state_q    <= ST_WAIT;
					case (func_q)
						bal_pkg::FUNC_DELETE: begin
							count_q <= count_q - CW'(1);
						end
						bal_pkg::FUNC_LOCATE: begin
							if (found_w[CAPACITY-1]) begin
								res_status_q <= bal_pkg::STATUS_DONE;
								res_index_q  <= idx_lo;
							end else begin
								res_status_q <= bal_pkg::STATUS_NOT_FOUND;
								res_index_q  <= 4'd0;
							end
						end
						default: begin
							count_q <= count_q + CW'(1);
						end
					endcase
				end
				ST_WAIT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_index_q  <= res_index_q;
						out_fill_q   <= cnt_lo;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = state_q == ST_IDLE;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_index_q;
	assign rsp.fill_count  = out_fill_q;

	// The fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// The count moves only at the end of the apply step
	a_count_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_APPLY) |=> $stable(count_q))
		else $error("fill count changed outside apply");

	// Cells move data only during the apply step
	a_cmd_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q.cmd != bal_pkg::CMD_HOLD) |-> (state_q == ST_APPLY))
		else $error("cell data move outside apply");

	// A finished item reaches the output register when it is free
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && (!out_valid_q || rsp.ready)) |=> (rsp.valid && state_q == ST_IDLE))
		else $error("result not handed to output");

	// A miss reports index zero
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == bal_pkg::STATUS_NOT_FOUND) |-> (rsp.found_index == 4'd0))
		else $error("miss with nonzero index");

endmodule

// ----- verif/bounded_array_list_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_top_test: self-checking bench for the bounded array list
// Drives insert, delete, locate and sorted-insert requests with random gaps
// and stalls. A shadow list predicts status, found index and fill count for
// every request, and each response is checked in order.
// ----------------------------------------------------------------------------
module bounded_array_list_top_test;

	localparam int CAPACITY       = 16;
	localparam int RANDOM_ITEMS   = 500;
	localparam int WATCHDOG_LIMIT = 2000;

	// One predicted response
	typedef struct {
		logic [1:0] status;
		logic [3:0] found_index;
		logic [4:0] fill_count;
	} list_result_t;

	// Shadow copy of the list plus the queue of responses still due
	class list_tracker;
		logic signed [31:0] shadow_entries [CAPACITY];
		int unsigned        shadow_fill;
		list_result_t       pending_results [$];
		int                 errors;
		int                 results_seen;
		int                 op_count [4];
		int                 rejects;
		int                 misses;
		int                 hits;

		function new();
			shadow_fill  = 0;
			errors       = 0;
			results_seen = 0;
			rejects      = 0;
			misses       = 0;
			hits         = 0;
			foreach (op_count[i]) op_count[i] = 0;
			foreach (shadow_entries[i]) shadow_entries[i] = '0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

		// Apply an accepted request to the shadow list and queue its response
		function void note_request(bal_pkg::func_t op, logic signed [31:0] v,
			logic [3:0] pos);
			list_result_t r;
			int           k;
			r.status      = bal_pkg::STATUS_DONE;
			r.found_index = '0;
			op_count[op]++;
			case (op)
				bal_pkg::FUNC_INSERT: begin
					if (shadow_fill >= CAPACITY || pos > shadow_fill) begin
						r.status = bal_pkg::STATUS_REJECT;
					end else begin
						for (k = shadow_fill; k > pos; k--)
							shadow_entries[k] = shadow_entries[k - 1];
						shadow_entries[pos] = v;
						shadow_fill++;
					end
				end
				bal_pkg::FUNC_DELETE: begin
					if (pos >= shadow_fill) begin
						r.status = bal_pkg::STATUS_REJECT;
					end else begin
						for (k = pos; k + 1 < shadow_fill; k++)
							shadow_entries[k] = shadow_entries[k + 1];
						shadow_fill--;
					end
				end
				bal_pkg::FUNC_LOCATE: begin
					r.status = bal_pkg::STATUS_NOT_FOUND;
					for (k = 0; k < shadow_fill; k++) begin
						if (r.status != bal_pkg::STATUS_DONE && shadow_entries[k] == v) begin
							r.status      = bal_pkg::STATUS_DONE;
							r.found_index = k[3:0];
						end
					end
					if (r.status == bal_pkg::STATUS_DONE) hits++;
				end
				default: begin
					if (shadow_fill >= CAPACITY) begin
						r.status = bal_pkg::STATUS_REJECT;
					end else begin
						// land after every entry that is less than or equal
						k = shadow_fill;
						while (k > 0 && shadow_entries[k - 1] > v) begin
							shadow_entries[k] = shadow_entries[k - 1];
							k--;
						end
						shadow_entries[k] = v;
						shadow_fill++;
					end
				end
			endcase
			if (r.status == bal_pkg::STATUS_REJECT) rejects++;
			if (r.status == bal_pkg::STATUS_NOT_FOUND) misses++;
			r.fill_count = shadow_fill[4:0];
			pending_results.push_back(r);
		endfunction

		// Compare one response with the oldest prediction
		task check_result(logic [1:0] st, logic [3:0] idx, logic [4:0] cnt);
			list_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("response %0d arrived with nothing outstanding", results_seen));
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status)
				report($sformatf("response %0d status got %0d want %0d",
					results_seen, st, want.status));
			if (idx !== want.found_index)
				report($sformatf("response %0d found_index got %0d want %0d",
					results_seen, idx, want.found_index));
			if (cnt !== want.fill_count)
				report($sformatf("response %0d fill_count got %0d want %0d",
					results_seen, cnt, want.fill_count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	bit          calm;
	int          quiet_cycles;
	list_tracker tracker = new();

	bal_req_if req ();
	bal_rsp_if rsp ();

	bounded_array_list_top #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Present one request after a random gap and hold it until taken
	task automatic push_request(bal_pkg::func_t op, logic signed [31:0] v, logic [3:0] pos);
		int gap;
		gap = calm ? 0 : $urandom_range(13, 0);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.func     <= op;
		req.value    <= v;
		req.position <= pos;
		do @(posedge clk); while (req.ready !== 1'b1);
		tracker.note_request(op, v, pos);
	endtask

	// Mix of small values (for duplicates), copies of stored entries, extremes and full-width noise
	function automatic logic signed [31:0] pick_value();
		int sel;
		sel = $urandom_range(99, 0);
		if (sel < 35)
			return 32'(int'($urandom_range(8, 0)) - 4);
		if (sel < 50 && tracker.shadow_fill > 0)
			return tracker.shadow_entries[$urandom_range(tracker.shadow_fill - 1, 0)];
		if (sel < 60) begin
			case ($urandom_range(3, 0))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0000_0000;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// Request side: reset, directed items, then random phases
	initial begin
		int                 n;
		int unsigned        fill;
		int                 sel;
		bit                 growing;
		bal_pkg::func_t     op;
		logic [3:0]         pos;
		logic signed [31:0] v;

		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.func     <= bal_pkg::FUNC_INSERT;
		req.value    <= '0;
		req.position <= '0;
		calm         = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty list corner cases
		push_request(bal_pkg::FUNC_LOCATE, 32'sd5, 4'd0);
		push_request(bal_pkg::FUNC_DELETE, 32'sd0, 4'd0);
		push_request(bal_pkg::FUNC_INSERT, 32'sd7, 4'd1);
		// extremes, equal entries in sorted order, locate hits
		push_request(bal_pkg::FUNC_INSERT, 32'sh8000_0000, 4'd0);
		push_request(bal_pkg::FUNC_INSERT, 32'sh7fff_ffff, 4'd1);
		push_request(bal_pkg::FUNC_SORTED, 32'sd0, 4'd15);
		push_request(bal_pkg::FUNC_SORTED, 32'sd0, 4'd0);
		push_request(bal_pkg::FUNC_LOCATE, 32'sd0, 4'd15);
		push_request(bal_pkg::FUNC_LOCATE, 32'sh7fff_ffff, 4'd0);
		push_request(bal_pkg::FUNC_DELETE, 32'sd0, 4'd15);
		push_request(bal_pkg::FUNC_DELETE, 32'sd0, 4'd3);
		push_request(bal_pkg::FUNC_SORTED, -32'sd1, 4'd0);
		// fill to capacity, then hit the full list
		while (tracker.shadow_fill < CAPACITY)
			push_request(bal_pkg::FUNC_SORTED, pick_value(), 4'($urandom_range(15, 0)));
		push_request(bal_pkg::FUNC_INSERT, 32'sd9, 4'd3);
		push_request(bal_pkg::FUNC_INSERT, 32'sd9, 4'd15);
		push_request(bal_pkg::FUNC_SORTED, 32'sh8000_0000, 4'd0);
		push_request(bal_pkg::FUNC_LOCATE, 32'sh1234_5678, 4'd0);

		// random phases that fill and drain the list
		growing = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) calm = ($urandom_range(3, 0) == 0);
			fill = tracker.shadow_fill;
			if (fill == 0) growing = 1'b1;
			else if (fill == CAPACITY && $urandom_range(2, 0) == 0) growing = 1'b0;
			sel = $urandom_range(99, 0);
			if (growing)
				op = sel < 35 ? bal_pkg::FUNC_INSERT : sel < 65 ? bal_pkg::FUNC_SORTED :
					sel < 85 ? bal_pkg::FUNC_LOCATE : bal_pkg::FUNC_DELETE;
			else
				op = sel < 45 ? bal_pkg::FUNC_DELETE : sel < 70 ? bal_pkg::FUNC_LOCATE :
					sel < 85 ? bal_pkg::FUNC_INSERT : bal_pkg::FUNC_SORTED;
			if ($urandom_range(3, 0) == 0)
				pos = 4'($urandom_range(15, 0));
			else if (op == bal_pkg::FUNC_DELETE && fill > 0)
				pos = 4'($urandom_range(fill - 1, 0));
			else
				pos = 4'($urandom_range(fill > 15 ? 15 : fill, 0));
			if (op == bal_pkg::FUNC_LOCATE && fill > 0 && $urandom_range(9, 0) < 6)
				v = tracker.shadow_entries[$urandom_range(fill - 1, 0)];
			else
				v = pick_value();
			push_request(op, v, pos);
		end
		req.valid <= 1'b0;

		// drain, then give the block time to show any stray response
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);

		$display("Checked %0d responses: insert %0d, delete %0d, locate %0d, sorted %0d.",
			tracker.results_seen, tracker.op_count[bal_pkg::FUNC_INSERT],
			tracker.op_count[bal_pkg::FUNC_DELETE], tracker.op_count[bal_pkg::FUNC_LOCATE],
			tracker.op_count[bal_pkg::FUNC_SORTED]);
		$display("Rejected %0d, locate hits %0d, locate misses %0d, mismatches %0d.",
			tracker.rejects, tracker.hits, tracker.misses, tracker.errors);
		if (tracker.errors == 0)
			$display("bounded_array_list_top regression: pass");
		else
			$display("bounded_array_list_top regression: fail");
		$finish;
	end

	// Response side: stall at random, check each item taken
	initial begin
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(13, 0);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
			tracker.check_result(rsp.status, rsp.found_index, rsp.fill_count);
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
			(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("bounded_array_list_top regression: fail");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
